// ----- rtl/core/svq_pkg.sv -----
// svq_pkg: shared types and constants for the split virtqueue ring manager.
// No dependencies; used by svq_ctrl, svq_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package svq_pkg;

   localparam int QUEUE_SIZE = 256;
   localparam int IDX_W      = $clog2(QUEUE_SIZE);
   localparam logic [15:0] LINK_END = 16'hFFFF;

   typedef enum logic [2:0] {
      FN_ADD_BUFFER = 3'd0,
      FN_GET_BUFFER = 3'd1,
      FN_POST_USED  = 3'd2,
      FN_KICK       = 3'd3,
      FN_SET_IRQ    = 3'd4,
      FN_READ_DESC  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_NO_USED = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TAG
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic issue;   // transaction accepted, launch first reads
      logic tag_rd;  // read tag of the returned descriptor
      logic commit;  // update state and load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_tag;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/svq_ram.sv -----
// svq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module svq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/svq_ctrl.sv -----
// svq_ctrl: sequencing state machine for the ring manager.
// Depends on svq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire svq_pkg::sts_type sts,
   output svq_pkg::cmd_type      cmd
);

   svq_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff != svq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svq_pkg::ST_IDLE: begin
            if (accept) state_in = svq_pkg::ST_EXEC;
         end
         svq_pkg::ST_EXEC: begin
            if (sts.need_tag) state_in = svq_pkg::ST_TAG;
            else if (sts.out_free) state_in = svq_pkg::ST_IDLE;
         end
         svq_pkg::ST_TAG: begin
            if (sts.out_free) state_in = svq_pkg::ST_IDLE;
         end
         default: state_in = svq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         svq_pkg::ST_IDLE: begin
            cmd.issue = accept;
         end
         svq_pkg::ST_EXEC: begin
            cmd.tag_rd = sts.need_tag;
            cmd.commit = !sts.need_tag && sts.out_free;
         end
         svq_pkg::ST_TAG: begin
            cmd.commit = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_issue_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> state_ff == svq_pkg::ST_EXEC)
      else $error("issue did not enter exec");

endmodule
`default_nettype wire

// ----- rtl/core/svq_datapath.sv -----
// svq_datapath: descriptor tables, rings, free list and response register.
// Depends on svq_pkg and svq_ram.
`timescale 1ns / 1ps
`default_nettype none
module svq_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire svq_pkg::cmd_type cmd,
   output svq_pkg::sts_type      sts,
   input  wire logic             csr_valid,
   input  wire logic [15:0]      csr_wdata,
   input  wire logic [2:0]       req_func,
   input  wire logic [63:0]      req_phys_addr,
   input  wire logic [31:0]      req_buf_length,
   input  wire logic             req_device_writable,
   input  wire logic [31:0]      req_user_tag,
   input  wire logic [7:0]       req_used_id,
   input  wire logic [31:0]      req_used_len,
   input  wire logic             req_no_notify,
   input  wire logic             req_enable_irq,
   input  wire logic [7:0]       req_probe_index,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_desc_slot,
   output logic [7:0]            rsp_avail_slot,
   output logic [31:0]           rsp_tag_out,
   output logic [31:0]           rsp_length_out,
   output logic                  rsp_was_enabled,
   output logic                  rsp_notify_fire,
   output logic [15:0]           rsp_notify_value,
   output logic [63:0]           rsp_addr_out,
   output logic                  rsp_writable_out
);

   localparam int QS = svq_pkg::QUEUE_SIZE;
   localparam int IW = svq_pkg::IDX_W;
   localparam int DW = 64 + 32 + 1;
   localparam int UW = 8 + 32;

   // captured transaction
   logic [2:0]  func_ff;
   logic [63:0] addr_ff;
   logic [31:0] len_ff, tag_ff, ulen_ff;
   logic        wf_ff, nonotify_ff, enirq_ff;
   logic [7:0]  uid_ff, probe_ff;

   // control state
   logic [15:0]   queue_index_ff;
   logic [15:0]   avail_count_ff, used_count_ff, consumed_count_ff, free_head_ff;
   logic [IW:0]   free_count_ff;
   logic          irq_supp_ff;
   logic [QS-1:0] link_vld_ff;
   logic          lvld_ff;
   logic          rsp_valid_ff;

   // response register
   logic [1:0]  status_ff;
   logic [7:0]  dslot_ff, aslot_ff;
   logic [31:0] tout_ff, lout_ff;
   logic        wen_ff, nfire_ff, wout_ff;
   logic [15:0] nval_ff;
   logic [63:0] aout_ff;

   // RAM ports
   logic [DW-1:0] desc_rdata;
   logic [UW-1:0] used_rdata;
   logic [31:0]   tag_rdata;
   logic [15:0]   link_rdata;
   logic          desc_we, used_we, tag_we, link_we;
   logic [IW-1:0] tag_waddr, link_waddr, used_waddr;
   logic [31:0]   tag_wdata;
   logic [15:0]   link_wdata;

   logic [15:0] link_val, pending;
   logic [7:0]  used_id;
   logic        add_ok, get_ok, post_ok, out_free;
   logic [1:0]  status_in;
   logic [7:0]  dslot_in, aslot_in;
   logic [31:0] tout_in, lout_in;
   logic        wen_in, nfire_in, wout_in;
   logic [15:0] nval_in;
   logic [63:0] aout_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign used_id  = used_rdata[UW-1 -: 8];
   assign pending  = used_count_ff - consumed_count_ff;

   assign add_ok  = (func_ff == svq_pkg::FN_ADD_BUFFER) && (free_count_ff != '0)
                    && (free_head_ff < 16'(QS));
   assign get_ok  = (func_ff == svq_pkg::FN_GET_BUFFER)
                    && (consumed_count_ff != used_count_ff);
   assign post_ok = (func_ff == svq_pkg::FN_POST_USED) && (pending < 16'(QS));

   assign sts.need_tag = get_ok;
   assign sts.out_free = out_free;

   // unwritten link entries hold their reset chain value
   always_comb begin
      if (lvld_ff) begin
         link_val = link_rdata;
      end else if (free_head_ff[IW-1:0] == IW'(QS - 1)) begin
         link_val = svq_pkg::LINK_END;
      end else begin
         link_val = 16'(free_head_ff[IW-1:0]) + 16'd1;
      end
   end

   assign desc_we    = cmd.commit && add_ok;
   assign used_we    = cmd.commit && post_ok;
   assign used_waddr = used_count_ff[IW-1:0];
   assign tag_we     = cmd.commit && (add_ok || get_ok);
   assign tag_waddr  = add_ok ? free_head_ff[IW-1:0] : used_id[IW-1:0];
   assign tag_wdata  = add_ok ? tag_ff : 32'd0;
   assign link_we    = tag_we;
   assign link_waddr = tag_waddr;
   assign link_wdata = add_ok ? svq_pkg::LINK_END : free_head_ff;

   svq_ram #(.WIDTH(DW), .DEPTH(QS)) u_desc_ram (
      .clock(clock), .wr_en(desc_we), .wr_addr(free_head_ff[IW-1:0]),
      .wr_data({addr_ff, len_ff, wf_ff}),
      .rd_en(cmd.issue), .rd_addr(req_probe_index[IW-1:0]), .rd_data(desc_rdata));

   svq_ram #(.WIDTH(UW), .DEPTH(QS)) u_used_ram (
      .clock(clock), .wr_en(used_we), .wr_addr(used_waddr),
      .wr_data({uid_ff, ulen_ff}),
      .rd_en(cmd.issue), .rd_addr(consumed_count_ff[IW-1:0]), .rd_data(used_rdata));

   svq_ram #(.WIDTH(32), .DEPTH(QS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
      .rd_en(cmd.tag_rd), .rd_addr(used_id[IW-1:0]), .rd_data(tag_rdata));

   svq_ram #(.WIDTH(16), .DEPTH(QS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_en(cmd.issue), .rd_addr(free_head_ff[IW-1:0]), .rd_data(link_rdata));

   // result of the captured transaction
   always_comb begin
      status_in = svq_pkg::STS_OK;
      dslot_in  = '0;
      aslot_in  = '0;
      tout_in   = '0;
      lout_in   = '0;
      wen_in    = 1'b0;
      nfire_in  = 1'b0;
      nval_in   = '0;
      aout_in   = '0;
      wout_in   = 1'b0;
      case (func_ff)
         svq_pkg::FN_ADD_BUFFER: begin
            if (add_ok) begin
               dslot_in = free_head_ff[7:0];
               aslot_in = 8'(avail_count_ff[IW-1:0]);
            end else begin
               status_in = svq_pkg::STS_NO_FREE;
            end
         end
         svq_pkg::FN_GET_BUFFER: begin
            if (get_ok) begin
               dslot_in = used_id;
               lout_in  = used_rdata[31:0];
               tout_in  = tag_rdata;
            end else begin
               status_in = svq_pkg::STS_NO_USED;
            end
         end
         svq_pkg::FN_POST_USED: begin
            if (!post_ok) status_in = svq_pkg::STS_FULL;
         end
         svq_pkg::FN_KICK: begin
            if (!nonotify_ff) begin
               nfire_in = 1'b1;
               nval_in  = queue_index_ff;
            end
         end
         svq_pkg::FN_SET_IRQ: begin
            wen_in = !irq_supp_ff;
         end
         svq_pkg::FN_READ_DESC: begin
            dslot_in = probe_ff;
            aout_in  = desc_rdata[DW-1 -: 64];
            lout_in  = desc_rdata[32:1];
            wout_in  = desc_rdata[0];
         end
         default: status_in = svq_pkg::STS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         func_ff     <= req_func;
         addr_ff     <= req_phys_addr;
         len_ff      <= req_buf_length;
         wf_ff       <= req_device_writable;
         tag_ff      <= req_user_tag;
         uid_ff      <= req_used_id;
         ulen_ff     <= req_used_len;
         nonotify_ff <= req_no_notify;
         enirq_ff    <= req_enable_irq;
         probe_ff    <= req_probe_index;
         lvld_ff     <= link_vld_ff[free_head_ff[IW-1:0]];
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         dslot_ff  <= dslot_in;
         aslot_ff  <= aslot_in;
         tout_ff   <= tout_in;
         lout_ff   <= lout_in;
         wen_ff    <= wen_in;
         nfire_ff  <= nfire_in;
         nval_ff   <= nval_in;
         aout_ff   <= aout_in;
         wout_ff   <= wout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_index_ff    <= '0;
         avail_count_ff    <= '0;
         used_count_ff     <= '0;
         consumed_count_ff <= '0;
         free_head_ff      <= '0;
         free_count_ff     <= (IW+1)'(QS);
         irq_supp_ff       <= 1'b0;
         link_vld_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) queue_index_ff <= csr_wdata;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (link_we) link_vld_ff[link_waddr] <= 1'b1;
         if (cmd.commit) begin
            if (add_ok) begin
               free_head_ff   <= link_val;
               free_count_ff  <= free_count_ff - (IW+1)'(1);
               avail_count_ff <= avail_count_ff + 16'd1;
            end
            if (get_ok) begin
               consumed_count_ff <= consumed_count_ff + 16'd1;
               free_head_ff      <= 16'(used_id);
               if (free_count_ff < (IW+1)'(QS)) begin
                  free_count_ff <= free_count_ff + (IW+1)'(1);
               end
            end
            if (post_ok) used_count_ff <= used_count_ff + 16'd1;
            if (func_ff == svq_pkg::FN_SET_IRQ) irq_supp_ff <= !enirq_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_desc_slot    = dslot_ff;
   assign rsp_avail_slot   = aslot_ff;
   assign rsp_tag_out      = tout_ff;
   assign rsp_length_out   = lout_ff;
   assign rsp_was_enabled  = wen_ff;
   assign rsp_notify_fire  = nfire_ff;
   assign rsp_notify_value = nval_ff;
   assign rsp_addr_out     = aout_ff;
   assign rsp_writable_out = wout_ff;

   a_free_count_max: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= (IW+1)'(QS))
      else $error("free count above queue size");

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without response");

   a_tag_only_get: assert property (@(posedge clock) disable iff (reset)
      cmd.tag_rd |-> func_ff == svq_pkg::FN_GET_BUFFER)
      else $error("tag read outside get_buffer");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= 16'(QS))
      else $error("used ring overrun");

endmodule
`default_nettype wire

// ----- rtl/core/split_virtqueue_ring_manager_core.sv -----
// Split virtqueue driver-side ring manager, top level.
// Depends on svq_pkg, svq_ctrl, svq_datapath and svq_ram.
//
// Usage:
//  - req_* channel: one operation per transaction (req_func selects add_buffer,
//    get_buffer, post_used, kick, set_interrupts or read_desc). req_stall is
//    high while an operation is in flight.
//  - rsp_* channel: exactly one result per operation, held in an output
//    register; a new request is taken while the previous result waits.
//  - csr_* channel: queue number used by kick; csr_ready is always high.
// Sequencing: rsp_valid is registered from the commit in EXEC, or in TAG for
// a get_buffer that finds a used element (its tag is read from the tag
// memory after the used ring entry names the descriptor). A new operation
// is taken only once the previous one commits; the RAM reads are registered.
// Reset: free list chained in index order (valid bits on the link memory
// stand in for the chain), counters zero but the free count (QS); interrupts
// enabled; no clearing pass. A stalled response holds; the block then accepts
// at most one more operation, reads its operands and waits before it commits.
`timescale 1ns / 1ps
`default_nettype none
module split_virtqueue_ring_manager_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [63:0] req_phys_addr,
   input  wire logic [31:0] req_buf_length,
   input  wire logic        req_device_writable,
   input  wire logic [31:0] req_user_tag,
   input  wire logic [7:0]  req_used_id,
   input  wire logic [31:0] req_used_len,
   input  wire logic        req_no_notify,
   input  wire logic        req_enable_irq,
   input  wire logic [7:0]  req_probe_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_desc_slot,
   output logic [7:0]       rsp_avail_slot,
   output logic [31:0]      rsp_tag_out,
   output logic [31:0]      rsp_length_out,
   output logic             rsp_was_enabled,
   output logic             rsp_notify_fire,
   output logic [15:0]      rsp_notify_value,
   output logic [63:0]      rsp_addr_out,
   output logic             rsp_writable_out
);

   svq_pkg::cmd_type cmd;
   svq_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   svq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .sts(sts), .cmd(cmd));

   svq_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_valid(csr_valid), .csr_wdata(csr_wdata),
      .req_func(req_func), .req_phys_addr(req_phys_addr),
      .req_buf_length(req_buf_length), .req_device_writable(req_device_writable),
      .req_user_tag(req_user_tag), .req_used_id(req_used_id),
      .req_used_len(req_used_len), .req_no_notify(req_no_notify),
      .req_enable_irq(req_enable_irq), .req_probe_index(req_probe_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_desc_slot(rsp_desc_slot), .rsp_avail_slot(rsp_avail_slot),
      .rsp_tag_out(rsp_tag_out), .rsp_length_out(rsp_length_out),
      .rsp_was_enabled(rsp_was_enabled), .rsp_notify_fire(rsp_notify_fire),
      .rsp_notify_value(rsp_notify_value), .rsp_addr_out(rsp_addr_out),
      .rsp_writable_out(rsp_writable_out));

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for split_virtqueue_ring_manager_core.
// Depends on svq_pkg and the core RTL; predicts every result from a local ring model.
module tb;

   localparam logic [2:0] FN_RSVD_6 = 3'd6;
   localparam logic [2:0] FN_RSVD_7 = 3'd7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int QS = svq_pkg::QUEUE_SIZE;

   typedef struct {
      logic [2:0]  func;
      logic [63:0] addr;
      logic [31:0] len;
      logic        wr;
      logic [31:0] tag;
      logic [7:0]  uid;
      logic [31:0] ulen;
      logic        nn;
      logic        en;
      logic [7:0]  probe;
   } ring_op_type;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  desc_slot;
      logic [7:0]  avail_slot;
      logic [31:0] tag_out;
      logic [31:0] length_out;
      logic        was_enabled;
      logic        notify_fire;
      logic [15:0] notify_value;
      logic [63:0] addr_out;
      logic        writable_out;
   } ring_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_valid, csr_ready;
   logic [15:0] csr_wdata;
   logic req_valid, req_stall;
   logic [2:0] req_func;
   logic [63:0] req_phys_addr;
   logic [31:0] req_buf_length, req_user_tag, req_used_len;
   logic req_device_writable, req_no_notify, req_enable_irq;
   logic [7:0] req_used_id, req_probe_index;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic [7:0] rsp_desc_slot, rsp_avail_slot;
   logic [31:0] rsp_tag_out, rsp_length_out;
   logic rsp_was_enabled, rsp_notify_fire, rsp_writable_out;
   logic [15:0] rsp_notify_value;
   logic [63:0] rsp_addr_out;

   split_virtqueue_ring_manager_core dut (.*);

   // ring model state
   logic [63:0] m_addr [QS];
   logic [31:0] m_len  [QS];
   logic        m_wr   [QS];
   logic [15:0] m_link [QS];
   logic [31:0] m_tag  [QS];
   logic [7:0]  m_uid  [QS];
   logic [31:0] m_ulen [QS];
   logic [15:0] m_avail_cnt, m_used_cnt, m_cons_cnt, m_free_head, m_qidx;
   int          m_free_cnt;
   logic        m_irq_off;

   ring_rsp_type pending_rsps[$];
   logic [7:0] in_flight[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic ring_rsp_type predict_ring(ring_op_type op);
      ring_rsp_type r;
      logic [7:0] d, pos;
      r = '{default: '0};
      case (op.func)
         svq_pkg::FN_ADD_BUFFER: begin
            if (m_free_cnt == 0 || m_free_head >= QS) begin
               r.status = svq_pkg::STS_NO_FREE;
            end else begin
               d = m_free_head[7:0];
               pos = m_avail_cnt[7:0];
               m_free_head = m_link[d];
               m_free_cnt--;
               m_addr[d] = op.addr;
               m_len[d] = op.len;
               m_wr[d] = op.wr;
               m_link[d] = svq_pkg::LINK_END;
               m_tag[d] = op.tag;
               m_avail_cnt++;
               r.desc_slot = d;
               r.avail_slot = pos;
            end
         end
         svq_pkg::FN_GET_BUFFER: begin
            if (m_cons_cnt == m_used_cnt) begin
               r.status = svq_pkg::STS_NO_USED;
            end else begin
               pos = m_cons_cnt[7:0];
               d = m_uid[pos];
               r.length_out = m_ulen[pos];
               r.desc_slot = d;
               m_cons_cnt++;
               r.tag_out = m_tag[d];
               m_tag[d] = '0;
               m_link[d] = m_free_head;
               m_free_head = {8'h00, d};
               if (m_free_cnt < QS) m_free_cnt++;
            end
         end
         svq_pkg::FN_POST_USED: begin
            if (16'(m_used_cnt - m_cons_cnt) >= QS) begin
               r.status = svq_pkg::STS_FULL;
            end else begin
               pos = m_used_cnt[7:0];
               m_uid[pos] = op.uid;
               m_ulen[pos] = op.ulen;
               m_used_cnt++;
            end
         end
         svq_pkg::FN_KICK: begin
            if (!op.nn) begin
               r.notify_fire = 1'b1;
               r.notify_value = m_qidx;
            end
         end
         svq_pkg::FN_SET_IRQ: begin
            r.was_enabled = !m_irq_off;
            m_irq_off = !op.en;
         end
         svq_pkg::FN_READ_DESC: begin
            r.desc_slot = op.probe;
            r.length_out = m_len[op.probe];
            r.addr_out = m_addr[op.probe];
            r.writable_out = m_wr[op.probe];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
      errors++;
   endtask

   // send one operation; waits for acceptance, leaves valid high
   task automatic send_op(ring_op_type op);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op.func;
      req_phys_addr <= op.addr;
      req_buf_length <= op.len;
      req_device_writable <= op.wr;
      req_user_tag <= op.tag;
      req_used_id <= op.uid;
      req_used_len <= op.ulen;
      req_no_notify <= op.nn;
      req_enable_irq <= op.en;
      req_probe_index <= op.probe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsps.push_back(predict_ring(op));
      if (op.func == svq_pkg::FN_ADD_BUFFER && pending_rsps[$].status == svq_pkg::STS_OK)
         in_flight.push_back(pending_rsps[$].desc_slot);
   endtask

   function automatic ring_op_type rand_op(logic [2:0] f);
      ring_op_type op;
      op.func = f;
      op.addr = {$urandom, $urandom};
      op.len = $urandom;
      op.wr = 1'($urandom_range(1));
      op.tag = $urandom;
      op.uid = 8'($urandom_range(255));
      op.ulen = $urandom;
      op.nn = 1'($urandom_range(1));
      op.en = 1'($urandom_range(1));
      op.probe = 8'($urandom_range(255));
      return op;
   endfunction

   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_queue_index(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_qidx = v;
   endtask

   // every descriptor gets written, then the free list runs dry
   task automatic test_exhaust_free_list();
      ring_op_type op;
      for (int i = 0; i <= QS; i++) begin
         op = rand_op(svq_pkg::FN_ADD_BUFFER);
         if (i == 0) begin
            op.addr = '0; op.len = '0; op.tag = '0; op.wr = 1'b0;
         end else if (i == 1) begin
            op.addr = '1; op.len = '1; op.tag = '1; op.wr = 1'b1;
         end
         send_op(op);
      end
      op = rand_op(svq_pkg::FN_READ_DESC); op.probe = 8'd0;   send_op(op);
      op.probe = 8'd1;   send_op(op);
      op.probe = 8'd255; send_op(op);
   endtask

   // fill the used ring to the brim, then drain it and underflow
   task automatic test_used_ring_limits();
      ring_op_type op;
      for (int i = 0; i <= QS; i++) begin
         op = rand_op(svq_pkg::FN_POST_USED);
         op.uid = in_flight.size() ? in_flight.pop_front() : 8'(i);
         if (i == 0) op.ulen = '0;
         if (i == 1) op.ulen = '1;
         send_op(op);
      end
      for (int i = 0; i <= QS; i++) send_op(rand_op(svq_pkg::FN_GET_BUFFER));
   endtask

   task automatic test_misc_ops();
      ring_op_type op;
      op = rand_op(svq_pkg::FN_KICK); op.nn = 1'b0; send_op(op);
      op.nn = 1'b1; send_op(op);
      op = rand_op(svq_pkg::FN_SET_IRQ); op.en = 1'b0; send_op(op);
      send_op(op);
      op.en = 1'b1; send_op(op);
      send_op(op);
      send_op(rand_op(FN_RSVD_6));
      send_op(rand_op(FN_RSVD_7));
      // return of descriptor 7, a double return when it is already free
      op = rand_op(svq_pkg::FN_POST_USED); op.uid = 8'd7; send_op(op);
      send_op(rand_op(svq_pkg::FN_GET_BUFFER));
      send_op(rand_op(svq_pkg::FN_ADD_BUFFER));
   endtask

   task automatic test_random_traffic(int n);
      ring_op_type op;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) op = rand_op(svq_pkg::FN_ADD_BUFFER);
         else if (pick < 52) begin
            op = rand_op(svq_pkg::FN_POST_USED);
            if (in_flight.size() != 0 && $urandom_range(15) != 0)
               op.uid = in_flight.pop_front();
         end
         else if (pick < 74) op = rand_op(svq_pkg::FN_GET_BUFFER);
         else if (pick < 81) op = rand_op(svq_pkg::FN_KICK);
         else if (pick < 88) op = rand_op(svq_pkg::FN_SET_IRQ);
         else if (pick < 97) op = rand_op(svq_pkg::FN_READ_DESC);
         else op = rand_op($urandom_range(1) ? FN_RSVD_6 : FN_RSVD_7);
         send_op(op);
      end
   endtask

   // receiver holds off long enough that the core backs up into req_stall
   task automatic test_backpressure();
      hold_cycles <= 200;
      test_random_traffic(12);
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0; csr_wdata = '0;
      req_valid = 1'b0; req_func = svq_pkg::FN_KICK; req_phys_addr = '0;
      req_buf_length = '0;
      req_device_writable = 1'b0; req_user_tag = '0; req_used_id = '0;
      req_used_len = '0; req_no_notify = 1'b0; req_enable_irq = 1'b0;
      req_probe_index = '0; rsp_stall = 1'b0;
      for (int i = 0; i < QS; i++) begin
         m_addr[i] = '0; m_len[i] = '0; m_wr[i] = 1'b0; m_tag[i] = '0;
         m_uid[i] = '0; m_ulen[i] = '0;
         m_link[i] = (i == QS - 1) ? svq_pkg::LINK_END : 16'(i + 1);
      end
      m_avail_cnt = '0; m_used_cnt = '0; m_cons_cnt = '0; m_free_head = '0;
      m_free_cnt = QS; m_irq_off = 1'b0; m_qidx = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_exhaust_free_list();
      test_misc_ops();
      test_used_ring_limits();
      drain_idle();
      write_queue_index(16'hFFFF);
      test_misc_ops();
      for (int ph = 0; ph < 4; ph++) begin
         drain_idle();
         write_queue_index(ph == 3 ? 16'h0000 : 16'($urandom));
         send_idle_pct <= (ph == 1) ? 64 : (ph == 3) ? 17 : 0;
         stall_pct <= (ph == 2) ? 64 : (ph == 3) ? 17 : 0;
         test_random_traffic(35);
         if (ph == 0) test_backpressure();
      end
      drain_idle();
      if (errors == 0)
         $display("split_virtqueue_ring_manager_core test passed");
      else
         $display("split_virtqueue_ring_manager_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      ring_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_status), '0);
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_status !== e.status)
               report_mismatch("status", 64'(rsp_status), 64'(e.status));
            if (rsp_desc_slot !== e.desc_slot)
               report_mismatch("desc_slot", 64'(rsp_desc_slot), 64'(e.desc_slot));
            if (rsp_avail_slot !== e.avail_slot)
               report_mismatch("avail_slot", 64'(rsp_avail_slot), 64'(e.avail_slot));
            if (rsp_tag_out !== e.tag_out)
               report_mismatch("tag_out", 64'(rsp_tag_out), 64'(e.tag_out));
            if (rsp_length_out !== e.length_out)
               report_mismatch("length_out", 64'(rsp_length_out), 64'(e.length_out));
            if (rsp_was_enabled !== e.was_enabled)
               report_mismatch("was_enabled", 64'(rsp_was_enabled), 64'(e.was_enabled));
            if (rsp_notify_fire !== e.notify_fire)
               report_mismatch("notify_fire", 64'(rsp_notify_fire), 64'(e.notify_fire));
            if (rsp_notify_value !== e.notify_value)
               report_mismatch("notify_value", 64'(rsp_notify_value),
                               64'(e.notify_value));
            if (rsp_addr_out !== e.addr_out)
               report_mismatch("addr_out", rsp_addr_out, e.addr_out);
            if (rsp_writable_out !== e.writable_out)
               report_mismatch("writable_out", 64'(rsp_writable_out),
                               64'(e.writable_out));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("split_virtqueue_ring_manager_core test failed");
         $finish;
      end
   end

endmodule
